// File: design/slx_pkg.sv
package slx_pkg;

  // Position counter and token length counter widths
  localparam int unsigned POSITION_BITS = 32;
  localparam int unsigned LENGTH_BITS   = 16;

  // Output field widths (fixed by the interface)
  localparam int unsigned START_W = 32;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned VALUE_W = 63;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [LENGTH_BITS-1:0]   len_t;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_END  = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    KIND_END    = 4'd0,
    KIND_ERROR  = 4'd1,
    KIND_IDENT  = 4'd2,
    KIND_INT    = 4'd3,
    KIND_PLUS   = 4'd4,
    KIND_MINUS  = 4'd5,
    KIND_LPAREN = 4'd6,
    KIND_RPAREN = 4'd7,
    KIND_STAR   = 4'd8,
    KIND_SLASH  = 4'd9
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [VALUE_W-1:0]  int_value;
    logic                overflow;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    length;
    logic [7:0]          err_byte;
    logic                last;
  } tok_t;

  // Up to two tokens produced by one item
  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  function automatic logic [START_W-1:0] out_start(pos_t p);
    logic [63:0] w;
    w = 64'(p);
    return w[START_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] out_length(len_t l);
    logic [31:0] w;
    w = 32'(l);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[LEN_W-1:0];
  endfunction

endpackage

// File: design/slx_lex.sv
module slx_lex (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_fire_i,
  input  logic               req_type_i,
  input  logic [7:0]         source_byte_i,
  output slx_pkg::push_t     push_o
);

  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_SLASH   = 3'd1,
    ST_COMMENT = 3'd2,
    ST_UNDER   = 3'd3,
    ST_IDENT   = 3'd4,
    ST_NUMBER  = 3'd5
  } lex_state_e;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [slx_pkg::VALUE_W-1:0] INT_MAX = '1;
  localparam slx_pkg::len_t LEN_MAX = '1;

  lex_state_e                  state_q, state_d;
  logic [slx_pkg::VALUE_W-1:0] accum_q, accum_d;
  logic                        ovf_q, ovf_d;
  slx_pkg::len_t               len_q, len_d;
  slx_pkg::pos_t               cstart_q, cstart_d;
  slx_pkg::pos_t               pos_q, pos_d;
  logic [7:0]                  first_q, first_d;

  logic [7:0] b;
  logic       is_digit, is_letter, is_space, is_ident;
  logic       pend_vld, emit_pend, do_start, stok_vld;
  logic [3:0] digit;
  logic [slx_pkg::VALUE_W+3:0] prod;
  logic       prod_ovf;
  slx_pkg::tok_t pend_tok, stok, end_tok;

  assign b         = source_byte_i;
  assign is_digit  = (b >= CH_0) && (b <= CH_9);
  assign is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  assign is_space  = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  assign is_ident  = is_digit || is_letter || (b == CH_UNDER);
  assign digit     = 4'(b - CH_0);

  // accum * 10 + digit, with saturation on overflow past 2^63-1
  assign prod = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
              + (slx_pkg::VALUE_W+4)'(digit);
  assign prod_ovf = ovf_q || (prod[slx_pkg::VALUE_W+3:slx_pkg::VALUE_W] != '0);

  // Token held by the current state, emitted when the run ends
  always_comb begin
    pend_tok       = '0;
    pend_tok.start = slx_pkg::out_start(cstart_q);
    pend_tok.length = slx_pkg::out_length(len_q);
    pend_vld       = 1'b1;
    unique case (state_q)
      ST_SLASH: begin
        pend_tok.kind   = slx_pkg::KIND_SLASH;
        pend_tok.length = 16'd1;
      end
      ST_UNDER: begin
        pend_tok.kind     = slx_pkg::KIND_ERROR;
        pend_tok.err_byte = first_q;
      end
      ST_IDENT:  pend_tok.kind = slx_pkg::KIND_IDENT;
      ST_NUMBER: begin
        pend_tok.kind      = slx_pkg::KIND_INT;
        pend_tok.int_value = accum_q;
        pend_tok.overflow  = ovf_q;
      end
      default: pend_vld = 1'b0;
    endcase
  end

  // Single-byte token from the start state
  always_comb begin
    stok        = '0;
    stok.start  = slx_pkg::out_start(pos_q);
    stok.length = 16'd1;
    stok_vld    = 1'b1;
    priority if (b == CH_PLUS)  stok.kind = slx_pkg::KIND_PLUS;
    else if (b == CH_MINUS)     stok.kind = slx_pkg::KIND_MINUS;
    else if (b == CH_LPAR)      stok.kind = slx_pkg::KIND_LPAREN;
    else if (b == CH_RPAR)      stok.kind = slx_pkg::KIND_RPAREN;
    else if (b == CH_STAR)      stok.kind = slx_pkg::KIND_STAR;
    else if (is_ident || is_space || (b == CH_SLASH)) stok_vld = 1'b0;
    else begin
      stok.kind     = slx_pkg::KIND_ERROR;
      stok.err_byte = b;
    end
  end

  always_comb begin
    end_tok       = '0;
    end_tok.kind  = slx_pkg::KIND_END;
    end_tok.start = slx_pkg::out_start(pos_q);
    end_tok.last  = 1'b1;
  end

  always_comb begin
    state_d   = state_q;
    accum_d   = accum_q;
    ovf_d     = ovf_q;
    len_d     = len_q;
    cstart_d  = cstart_q;
    pos_d     = pos_q;
    first_d   = first_q;
    emit_pend = 1'b0;
    do_start  = 1'b0;
    push_o    = '0;

    if (item_fire_i && (req_type_i == slx_pkg::REQ_END)) begin
      // flush pending token, then end; return to reset state
      if (pend_vld) begin
        push_o.n  = 2'd2;
        push_o.t0 = pend_tok;
        push_o.t1 = end_tok;
      end else begin
        push_o.n  = 2'd1;
        push_o.t0 = end_tok;
      end
      state_d  = ST_START;
      accum_d  = '0;
      ovf_d    = 1'b0;
      len_d    = '0;
      cstart_d = '0;
      pos_d    = '0;
      first_d  = '0;
    end else if (item_fire_i) begin
      pos_d = pos_q + 1'b1;
      unique case (state_q)
        ST_SLASH: begin
          if (b == CH_SLASH) state_d = ST_COMMENT;
          else begin
            emit_pend = 1'b1;
            do_start  = 1'b1;
          end
        end
        ST_COMMENT: begin
          if ((b == CH_LF) || (b == CH_CR)) state_d = ST_START;
        end
        ST_UNDER, ST_IDENT: begin
          if (is_ident) begin
            if (len_q != LEN_MAX) len_d = len_q + 1'b1;
            state_d = ST_IDENT;
          end else begin
            emit_pend = 1'b1;
            do_start  = 1'b1;
          end
        end
        ST_NUMBER: begin
          if (is_digit) begin
            if (len_q != LEN_MAX) len_d = len_q + 1'b1;
            accum_d = prod_ovf ? INT_MAX : prod[slx_pkg::VALUE_W-1:0];
            ovf_d   = prod_ovf;
          end else begin
            emit_pend = 1'b1;
            do_start  = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        state_d = ST_START;
        if (is_ident) begin
          cstart_d = pos_q;
          len_d    = slx_pkg::len_t'(1);
          first_d  = b;
          accum_d  = '0;
          ovf_d    = 1'b0;
          if (is_digit) begin
            state_d = ST_NUMBER;
            accum_d = slx_pkg::VALUE_W'(digit);
          end else if (is_letter) begin
            state_d = ST_IDENT;
          end else begin
            state_d = ST_UNDER;
          end
        end else if (b == CH_SLASH) begin
          state_d  = ST_SLASH;
          cstart_d = pos_q;
        end
      end

      if (emit_pend && pend_vld) begin
        push_o.t0 = pend_tok;
        if (do_start && stok_vld) begin
          push_o.n  = 2'd2;
          push_o.t1 = stok;
          push_o.t1.last = 1'b1;
        end else begin
          push_o.n  = 2'd1;
          push_o.t0.last = 1'b1;
        end
      end else if (do_start && stok_vld) begin
        push_o.n  = 2'd1;
        push_o.t0 = stok;
        push_o.t0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_START;
      accum_q  <= '0;
      ovf_q    <= 1'b0;
      len_q    <= '0;
      cstart_q <= '0;
      pos_q    <= '0;
      first_q  <= '0;
    end else begin
      state_q  <= state_d;
      accum_q  <= accum_d;
      ovf_q    <= ovf_d;
      len_q    <= len_d;
      cstart_q <= cstart_d;
      pos_q    <= pos_d;
      first_q  <= first_d;
    end
  end

  // end of source restarts offsets at zero
  a_end_resets_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_fire_i && (req_type_i == slx_pkg::REQ_END)) |=> (pos_q == '0) && (state_q == ST_START))
    else $error("position not cleared after end of source");

  // a saturated literal always holds the maximum value
  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (accum_q == INT_MAX))
    else $error("overflowed literal not saturated");

endmodule

// File: design/slx_fifo.sv
module slx_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slx_pkg::push_t       push_i,
  output logic                 room2_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output slx_pkg::tok_t        head_o
);

  localparam int unsigned CW = slx_pkg::FIFO_AW + 1;

  slx_pkg::tok_t mem_q [slx_pkg::FIFO_DEPTH];
  logic [slx_pkg::FIFO_AW-1:0] wr_q, rd_q;
  logic [CW-1:0]               cnt_q;
  logic                        pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign room2_o = (cnt_q <= CW'(slx_pkg::FIFO_DEPTH - 2));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.t0;
    if (push_i.n == 2'd2) mem_q[wr_q + 1'b1] <= push_i.t1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + slx_pkg::FIFO_AW'(push_i.n);
      rd_q  <= rd_q + slx_pkg::FIFO_AW'(pop);
      cnt_q <= cnt_q + CW'(push_i.n) - CW'(pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> (cnt_q <= CW'(slx_pkg::FIFO_DEPTH) - CW'(push_i.n)))
    else $error("result queue overrun");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(slx_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");

endmodule

// File: design/source_byte_lexer.sv
// source_byte_lexer: byte-serial lexer for a small expression language.
// Input channel (in_valid_i / in_stall_o): one transaction carries either a
// source byte (req_type_i = 0) or the end-of-source mark (req_type_i = 1).
// Output channel (out_valid_o / out_stall_i): one token per transaction, with
// kind, integer value and overflow flag, start offset, length, error byte and
// last_of_run, which marks the final token caused by one input transaction.
// One input can give zero, one or two tokens: a byte that ends a pending token
// is then lexed from the start state, and end of source flushes the pending
// token before the end token.
// An input waits in the input register until the queue has room for two
// tokens, then is lexed and queued. Throughput: one input per cycle while the
// queue has that room and each input gives at most one token. The limit is
// the single output port of the 4-entry queue, one token per transaction.
// When the receiver stalls, tokens collect in the queue; the input register
// holds its item (in_stall_o high) until the queue has room for two tokens.
// Reset clears the lexer to the start state at offset zero and empties the
// queue; end of source does the same for the lexer.
module source_byte_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  source_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [62:0] int_value_o,
  output logic        overflow_o,
  output logic [31:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic [7:0]  error_byte_o,
  output logic        last_of_run_o
);

  // input register
  logic       item_vld_q;
  logic       item_type_q;
  logic [7:0] item_byte_q;

  logic           room2;
  logic           fire;
  slx_pkg::push_t push;
  slx_pkg::tok_t  head;

  // lex the held item only when both of its possible tokens fit
  assign fire       = item_vld_q && room2;
  assign in_stall_o = item_vld_q && !room2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      item_vld_q <= 1'b1;
    end else if (fire) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_type_q <= req_type_i;
      item_byte_q <= source_byte_i;
    end
  end

  slx_lex u_lex (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_fire_i   (fire),
    .req_type_i    (item_type_q),
    .source_byte_i (item_byte_q),
    .push_o        (push)
  );

  slx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .valid_o (out_valid_o),
    .pop_i   (!out_stall_i),
    .head_o  (head)
  );

  assign token_kind_o   = head.kind;
  assign int_value_o    = head.int_value;
  assign overflow_o     = head.overflow;
  assign token_start_o  = head.start;
  assign token_length_o = head.length;
  assign error_byte_o   = head.err_byte;
  assign last_of_run_o  = head.last;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

// Testbench for source_byte_lexer.
// Bytes and end-of-source marks go in one transaction at a time. Each accepted
// transaction runs through a local lexer that computes the tokens the block
// should emit. A receive process compares every output transaction, field by
// field, against the oldest token still owed. Both sides idle at random, at rates
// set phase by phase, and the sender drains the block between phases.
module testbench;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam logic [62:0] INT_SAT     = {63{1'b1}};
  localparam logic [15:0] LEN_SAT     = 16'hFFFF;

  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_UNDER  = "_";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Scanner states of the local lexer
  typedef enum logic [2:0] {
    LX_START,
    LX_SLASH,
    LX_COMMENT,
    LX_UNDER,
    LX_IDENT,
    LX_NUMBER
  } lex_state_e;

  // Clock, reset and ports; every input starts at a known value
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        req_type_i    = slx_pkg::REQ_BYTE;
  logic [7:0]  source_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [3:0]  token_kind_o;
  logic [62:0] int_value_o;
  logic        overflow_o;
  logic [31:0] token_start_o;
  logic [15:0] token_length_o;
  logic [7:0]  error_byte_o;
  logic        last_of_run_o;

  // Idle rates, in percent, for the sender and the receiver
  int unsigned send_idle_pct  = 18;
  int unsigned recv_stall_pct = 45;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;

  // Local lexer state
  lex_state_e  lx_state;
  logic [62:0] acc_value;
  logic        acc_ovf;
  logic [15:0] cur_len;
  logic [31:0] cur_start;
  logic [31:0] byte_pos;
  logic [7:0]  first_byte;

  slx_pkg::tok_t token_batch[$];      // tokens of the transaction being lexed
  slx_pkg::tok_t expected_tokens[$];  // tokens owed by the block, oldest first
  slx_pkg::tok_t head_token;

  always #1 clk_i = ~clk_i;

  source_byte_lexer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .source_byte_i  (source_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .int_value_o    (int_value_o),
    .overflow_o     (overflow_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .error_byte_o   (error_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

  // ---------------------------------------------------------------------------
  // Local lexer
  // ---------------------------------------------------------------------------

  function automatic bit is_digit(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic bit is_word(logic [7:0] b);
    return is_letter(b) || is_digit(b) || b == CH_UNDER;
  endfunction

  function automatic bit is_space(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
           b == CH_FF || b == CH_CR;
  endfunction

  function automatic void clear_lexer();
    lx_state   = LX_START;
    acc_value  = '0;
    acc_ovf    = 1'b0;
    cur_len    = '0;
    cur_start  = '0;
    byte_pos   = '0;
    first_byte = '0;
  endfunction

  function automatic void push_token(slx_pkg::kind_e k, logic [62:0] v, logic o,
                                     logic [31:0] s, logic [15:0] l, logic [7:0] e);
    slx_pkg::tok_t t;
    t.kind      = k;
    t.int_value = v;
    t.overflow  = o;
    t.start     = s;
    t.length    = l;
    t.err_byte  = e;
    t.last      = 1'b0;
    token_batch.push_back(t);
  endfunction

  function automatic void begin_text(logic [7:0] b, lex_state_e st);
    lx_state   = st;
    cur_start  = byte_pos;
    cur_len    = 16'd1;
    first_byte = b;
    acc_value  = '0;
    acc_ovf    = 1'b0;
  endfunction

  function automatic void grow_text();
    if (cur_len != LEN_SAT) cur_len++;
  endfunction

  // Decimal accumulate; sticks at 2^63-1 once it would pass it
  function automatic void add_digit(logic [7:0] b);
    logic [63:0] d;
    d = 64'(b - CH_ZERO);
    if (acc_ovf || {1'b0, acc_value} > (64'(INT_SAT) - d) / 64'd10) begin
      acc_value = INT_SAT;
      acc_ovf   = 1'b1;
    end else begin
      acc_value = acc_value * 63'd10 + 63'(d);
    end
  endfunction

  // Emit whatever token the current state holds open
  function automatic void flush_pending();
    case (lx_state)
      LX_SLASH:  push_token(slx_pkg::KIND_SLASH, '0, 1'b0, cur_start, 16'd1, '0);
      LX_UNDER:  push_token(slx_pkg::KIND_ERROR, '0, 1'b0, cur_start, cur_len, first_byte);
      LX_IDENT:  push_token(slx_pkg::KIND_IDENT, '0, 1'b0, cur_start, cur_len, '0);
      LX_NUMBER: push_token(slx_pkg::KIND_INT, acc_value, acc_ovf, cur_start, cur_len, '0);
      default: ;
    endcase
  endfunction

  function automatic void lex_from_start(logic [7:0] b);
    lx_state = LX_START;
    if (is_digit(b)) begin
      begin_text(b, LX_NUMBER);
      add_digit(b);
    end else if (is_letter(b)) begin
      begin_text(b, LX_IDENT);
    end else if (b == CH_UNDER) begin
      begin_text(b, LX_UNDER);
    end else if (b == CH_PLUS) begin
      push_token(slx_pkg::KIND_PLUS, '0, 1'b0, byte_pos, 16'd1, '0);
    end else if (b == CH_MINUS) begin
      push_token(slx_pkg::KIND_MINUS, '0, 1'b0, byte_pos, 16'd1, '0);
    end else if (b == CH_LPAREN) begin
      push_token(slx_pkg::KIND_LPAREN, '0, 1'b0, byte_pos, 16'd1, '0);
    end else if (b == CH_RPAREN) begin
      push_token(slx_pkg::KIND_RPAREN, '0, 1'b0, byte_pos, 16'd1, '0);
    end else if (b == CH_STAR) begin
      push_token(slx_pkg::KIND_STAR, '0, 1'b0, byte_pos, 16'd1, '0);
    end else if (b == CH_SLASH) begin
      lx_state  = LX_SLASH;
      cur_start = byte_pos;
    end else if (!is_space(b)) begin
      push_token(slx_pkg::KIND_ERROR, '0, 1'b0, byte_pos, 16'd1, b);
    end
  endfunction

  // Lex one accepted transaction and queue the tokens it owes
  function automatic void predict_tokens(slx_pkg::req_e rt, logic [7:0] b);
    slx_pkg::tok_t t;
    token_batch.delete();
    if (rt == slx_pkg::REQ_END) begin
      // pending token first, then end; a pending comment just vanishes
      flush_pending();
      push_token(slx_pkg::KIND_END, '0, 1'b0, byte_pos, 16'd0, '0);
      clear_lexer();
    end else begin
      case (lx_state)
        LX_SLASH: begin
          if (b == CH_SLASH) begin
            lx_state = LX_COMMENT;
          end else begin
            flush_pending();
            lex_from_start(b);
          end
        end
        LX_COMMENT: begin
          if (b == CH_LF || b == CH_CR) lx_state = LX_START;
        end
        LX_UNDER: begin
          if (is_word(b)) begin
            grow_text();
            lx_state = LX_IDENT;
          end else begin
            flush_pending();
            lex_from_start(b);
          end
        end
        LX_IDENT: begin
          if (is_word(b)) begin
            grow_text();
          end else begin
            flush_pending();
            lex_from_start(b);
          end
        end
        LX_NUMBER: begin
          if (is_digit(b)) begin
            grow_text();
            add_digit(b);
          end else begin
            flush_pending();
            lex_from_start(b);
          end
        end
        default: lex_from_start(b);
      endcase
      byte_pos++;
    end
    if (token_batch.size() != 0) begin
      t = token_batch.pop_back();
      t.last = 1'b1;
      token_batch.push_back(t);
    end
    foreach (token_batch[i]) expected_tokens.push_back(token_batch[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one transaction, hold it through stalls, lex it once taken
  task automatic send_item(slx_pkg::req_e rt, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= rt;
    source_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_tokens(rt, b);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(slx_pkg::REQ_BYTE, s[i]);
  endtask

  // Hold the input idle until every owed token has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_tokens.size() != 0);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_word_byte();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5) return rand_letter();
    if (pick < 9) return 8'(CH_ZERO + $urandom_range(9));
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(5))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_LPAREN;
      3:       return CH_RPAREN;
      4:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // One lexical fragment: mostly well-formed pieces, some raw noise
  task automatic send_random_fragment();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 22) begin
      // identifier, sometimes with a leading underscore, sometimes a lone one
      send_item(slx_pkg::REQ_BYTE, $urandom_range(3) == 0 ? CH_UNDER : rand_letter());
      n = $urandom_range(8);
      repeat (n) send_item(slx_pkg::REQ_BYTE, rand_word_byte());
    end else if (pick < 42) begin
      // integer; now and then long enough to saturate
      n = ($urandom_range(7) == 0) ? $urandom_range(22, 18) : $urandom_range(6, 1);
      repeat (n) send_item(slx_pkg::REQ_BYTE, 8'(CH_ZERO + $urandom_range(9)));
    end else if (pick < 62) begin
      send_item(slx_pkg::REQ_BYTE, rand_operator());
    end else if (pick < 74) begin
      send_item(slx_pkg::REQ_BYTE, rand_space());
    end else if (pick < 82) begin
      send_item(slx_pkg::REQ_BYTE, CH_SLASH);
      send_item(slx_pkg::REQ_BYTE, CH_SLASH);
      n = $urandom_range(6);
      repeat (n) send_item(slx_pkg::REQ_BYTE, 8'($urandom_range(255)));
      send_item(slx_pkg::REQ_BYTE, $urandom_range(1) ? CH_LF : CH_CR);
    end else if (pick < 95) begin
      send_item(slx_pkg::REQ_BYTE, 8'($urandom_range(255)));
    end else begin
      send_item(slx_pkg::REQ_END, 8'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every token kind but integer; a lone underscore ends with a second token
  // from the same byte; comment skipped; unknown bytes, high and zero
  task automatic test_token_kinds();
    send_text("ab_9 _+-()*/ /x//c\n@");
    send_item(slx_pkg::REQ_BYTE, 8'hFF);
    send_item(slx_pkg::REQ_BYTE, 8'h00);
    send_item(slx_pkg::REQ_END, 8'hA5);
  endtask

  // End of source: alone, after a number, inside a comment, after a lone
  // underscore and after a slash; carriage return closes a comment
  task automatic test_end_of_source();
    send_item(slx_pkg::REQ_END, 8'h5A);
    send_text("12");
    send_item(slx_pkg::REQ_END, 8'h00);
    send_text("//q");
    send_item(slx_pkg::REQ_END, 8'hFF);
    send_text("_");
    send_item(slx_pkg::REQ_END, 8'h00);
    send_text("/");
    send_item(slx_pkg::REQ_END, 8'h00);
    send_text("//\r7");
    send_item(slx_pkg::REQ_END, 8'h00);
  endtask

  // Largest value that still fits without saturation
  task automatic test_int_limit();
    send_text("9223372036854775807");
    send_item(slx_pkg::REQ_END, 8'h00);
  endtask

  task automatic test_random_stream(int unsigned count);
    int unsigned target;
    target = items_sent + count;
    while (items_sent < target) send_random_fragment();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: check each output transaction, then pick the next stall
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tokens.size() == 0) begin
        $error("token kind %0d at start %0d with none owed", token_kind_o, token_start_o);
        mismatch_count++;
      end else begin
        head_token = expected_tokens.pop_front();
        check_field("token_kind", 64'(head_token.kind), 64'(token_kind_o));
        check_field("int_value", 64'(head_token.int_value), 64'(int_value_o));
        check_field("overflow", 64'(head_token.overflow), 64'(overflow_o));
        check_field("token_start", 64'(head_token.start), 64'(token_start_o));
        check_field("token_length", 64'(head_token.length), 64'(token_length_o));
        check_field("error_byte", 64'(head_token.err_byte), 64'(error_byte_o));
        check_field("last_of_run", 64'(head_token.last), 64'(last_of_run_o));
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clear_lexer();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 1: sender idles a little, receiver stalls a lot
    send_idle_pct  = 18;
    recv_stall_pct = 45;
    test_token_kinds();
    test_end_of_source();
    test_int_limit();
    test_random_stream(300);
    wait_drained();

    // Phase 2: the other way round
    send_idle_pct  = 45;
    recv_stall_pct = 18;
    test_random_stream(300);
    wait_drained();

    // Phase 3: full rate both ways
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_stream(300);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
